>>> rtl/cma_pkg.sv
package cma_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int BLOCK_LENGTH    = 64;
  localparam int WSIZE_W         = 5;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;
  // window sum of up to 31 samples
  localparam int SUM_W           = SAMPLE_WIDTH + WSIZE_W;
  localparam int DCNT_W          = $clog2(SUM_W);

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last_sample;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] average;
    logic                    last_result;
  } out_word_t;

  typedef struct packed {
    logic load;       // take input word into the store
    logic blk_init;   // block closed: latch length, restart result index
    logic res_init;   // start a new result window
    logic rew_step;   // move window pointer back one place
    logic step_clr;
    logic rd_issue;   // read store at pointer, advance pointer
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rew_done;
    logic acc_last;
    logic div_done;
    logic last_j;
  } status_t;

endpackage

>>> rtl/cma_ctrl.sv
module cma_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last_sample,
  input  cma_pkg::status_t status,
  output cma_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [6:0] {
    IDLE   = 7'b0000001,
    REWIND = 7'b0000010,
    ACCUM  = 7'b0000100,
    FLUSH  = 7'b0001000,
    DINIT  = 7'b0010000,
    DIVIDE = 7'b0100000,
    EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_sample) begin
            cmd.blk_init = 1'b1;
            cmd.res_init = 1'b1;
            state_next   = REWIND;
          end
        end
      end
      REWIND: begin
        if (status.rew_done) begin
          cmd.step_clr = 1'b1;
          state_next   = ACCUM;
        end else begin
          cmd.rew_step = 1'b1;
        end
      end
      ACCUM: begin
        cmd.rd_issue = 1'b1;
        if (status.acc_last) begin
          state_next = FLUSH;
        end
      end
      FLUSH: begin
        state_next = DINIT;
      end
      DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = DIVIDE;
      end
      DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_j) begin
          state_next = IDLE;
        end else begin
          cmd.res_init = 1'b1;
          state_next   = REWIND;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

>>> rtl/cma_dp.sv
module cma_dp #(
  parameter int BLOCK_LENGTH = cma_pkg::BLOCK_LENGTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cma_pkg::cmd_t                cmd,
  input  cma_pkg::in_word_t            item,
  input  logic                         cfg_we,
  input  logic [cma_pkg::WSIZE_W-1:0]  cfg_data,
  output cma_pkg::status_t             status,
  output cma_pkg::out_word_t           result,
  output logic                         strobe
);

  localparam int CW = $clog2(BLOCK_LENGTH + 1);
  localparam int IW = $clog2(BLOCK_LENGTH);
  localparam int SW = cma_pkg::SAMPLE_WIDTH;
  localparam int WW = cma_pkg::WSIZE_W;
  localparam int AW = cma_pkg::SUM_W;
  localparam int DW = cma_pkg::DCNT_W;

  logic [SW-1:0] mem [BLOCK_LENGTH];
  logic [SW-1:0] rdata;
  logic          rd_pending;

  logic [WW-1:0] wsize;
  logic [CW-1:0] count;
  logic [CW-1:0] len;
  logic [IW-1:0] j;
  logic [IW-1:0] j_next;
  logic [IW-1:0] ptr;
  logic [WW-1:0] step;
  logic [AW-1:0] acc;
  logic [AW-1:0] quot;
  logic [WW-1:0] rem;
  logic [DW-1:0] dcnt;

  logic [WW-1:0] w_eff;
  logic [CW-1:0] len_m1;
  logic          full;
  logic [WW:0]   trial;
  logic          fits;

  assign w_eff  = (wsize == '0) ? WW'(1) : wsize;
  assign len_m1 = len - CW'(1);
  assign full   = (count == CW'(BLOCK_LENGTH));

  assign status.rew_done = (step == (w_eff >> 1));
  assign status.acc_last = (step == w_eff - WW'(1));
  assign status.div_done = (dcnt == DW'(AW - 1));
  assign status.last_j   = (j == len_m1[IW-1:0]);

  assign j_next = cmd.blk_init ? '0 : (cmd.emit ? j + IW'(1) : j);

  // restoring divide, one quotient bit per cycle
  assign trial = {rem, quot[AW-1]};
  assign fits  = (trial >= {1'b0, w_eff});

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[IW-1:0]] <= item.sample;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsize      <= cma_pkg::WSIZE_RESET;
      count      <= '0;
      rd_pending <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      if (cfg_we) begin
        wsize <= cfg_data;
      end
      if (cmd.load) begin
        if (cmd.blk_init) begin
          count <= '0;
        end else if (!full) begin
          count <= count + CW'(1);
        end
      end
      rd_pending <= cmd.rd_issue;
      strobe     <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_init) begin
      len <= full ? count : count + CW'(1);
    end
    j <= j_next;

    if (cmd.res_init) begin
      ptr  <= j_next;
      step <= '0;
      acc  <= '0;
    end else begin
      if (cmd.rew_step) begin
        ptr  <= (ptr == '0) ? len_m1[IW-1:0] : ptr - IW'(1);
        step <= step + WW'(1);
      end
      if (cmd.step_clr) begin
        step <= '0;
      end
      if (cmd.rd_issue) begin
        ptr  <= (ptr == len_m1[IW-1:0]) ? '0 : ptr + IW'(1);
        step <= step + WW'(1);
      end
      if (rd_pending) begin
        acc <= acc + AW'(rdata);
      end
    end

    if (cmd.div_init) begin
      quot <= acc;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[AW-2:0], fits};
      rem  <= fits ? WW'(trial - {1'b0, w_eff}) : trial[WW-1:0];
      dcnt <= dcnt + DW'(1);
    end

    if (cmd.emit) begin
      result.average     <= quot[SW-1:0];
      result.last_result <= status.last_j;
    end
  end

endmodule

>>> rtl/circular_moving_average_core.sv
// Channel  Ports                    Handshake
// input    item (sample, last)      start, taken when start && !busy
// result   result (average, last)   strobe, one cycle, no back-pressure
// config   cfg_we, cfg_data         written on any edge with cfg_we high
//
// A word without the last flag is stored and busy stays low. A last word closes
// the block; each of the L results is then formed by a rewind of the window
// pointer, a one-read-per-cycle window sum over the sample memory and a 21-step
// serial divider. busy stays high until the final result's strobe is issued.
// Sync reset clears control and sets window_size to 4; the memory is not cleared.
module circular_moving_average_core #(
  parameter int BLOCK_LENGTH = cma_pkg::BLOCK_LENGTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  cma_pkg::in_word_t           item,
  output logic                        strobe,
  output cma_pkg::out_word_t          result,
  input  logic                        cfg_we,
  input  logic [cma_pkg::WSIZE_W-1:0] cfg_data
);

  cma_pkg::cmd_t    cmd;
  cma_pkg::status_t status;

  cma_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_sample (item.last_sample),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  cma_dp #(
    .BLOCK_LENGTH (BLOCK_LENGTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .status   (status),
    .result   (result),
    .strobe   (strobe)
  );

endmodule

>>> verif/circular_moving_average_core_test.sv
module circular_moving_average_core_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SW             = cma_pkg::SAMPLE_WIDTH;
  localparam int WW             = cma_pkg::WSIZE_W;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  cma_pkg::in_word_t  item_word = '0;
  logic               strobe;
  cma_pkg::out_word_t result_word;
  logic               cfg_we = 1'b0;
  logic [WW-1:0]      cfg_data = '0;

  circular_moving_average_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item_word),
    .strobe   (strobe),
    .result   (result_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the block: sample memory, fill level, window register
  logic [SW-1:0]      sample_mem [cma_pkg::BLOCK_LENGTH];
  int                 fill_count = 0;
  logic [WW-1:0]      win_size = cma_pkg::WSIZE_RESET;
  cma_pkg::out_word_t expected_avgs [$];
  cma_pkg::out_word_t avg_want;

  int mismatches = 0;
  int avgs_checked = 0;
  int words_sent = 0;
  int blocks_closed = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  function automatic logic [SW-1:0] window_mean(int pos, int len, int w);
    longint unsigned acc;
    int              base;
    acc  = 0;
    // bias by len*32 so the back-off by w/2 never goes negative
    base = pos + len * 32 - w / 2;
    for (int i = 0; i < w; i++)
      acc += sample_mem[(base + i) % len];
    return SW'(acc / w);
  endfunction

  function automatic void absorb_word(cma_pkg::in_word_t w);
    int                 len;
    int                 eff_win;
    cma_pkg::out_word_t r;
    // words past a full store are dropped, but a last flag still closes the block
    if (fill_count < cma_pkg::BLOCK_LENGTH) begin
      sample_mem[fill_count] = w.sample;
      fill_count++;
    end
    if (w.last_sample) begin
      len     = fill_count;
      eff_win = (win_size == 0) ? 1 : int'(win_size);
      for (int j = 0; j < len; j++) begin
        r.average     = window_mean(j, len, eff_win);
        r.last_result = (j == len - 1);
        expected_avgs.push_back(r);
      end
      fill_count = 0;
      blocks_closed++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_avgs.size() == 0) begin
        $error("unexpected result word: average %0h last_result %0b",
               result_word.average, result_word.last_result);
        mismatches++;
      end else begin
        avg_want = expected_avgs.pop_front();
        avgs_checked++;
        if (result_word.average !== avg_want.average) begin
          $error("average: expected %0h, actual %0h", avg_want.average, result_word.average);
          mismatches++;
        end
        if (result_word.last_result !== avg_want.last_result) begin
          $error("last_result: expected %0b, actual %0b",
                 avg_want.last_result, result_word.last_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [SW-1:0] s, input logic l);
    cma_pkg::in_word_t w;
    w = {s, l};
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start     <= 1'b1;
    item_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_word(w);
    words_sent++;
  endtask

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++)
      send_word(SW'($urandom_range(0, 65535)), i == len - 1);
  endtask

  // hold off until every average of the open blocks has come back
  task automatic drain();
    start <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [WW-1:0] w);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we   <= 1'b0;
    win_size = w;
  endtask

  // window left at its reset value of 4
  task automatic test_reset_window();
    send_word(16'h0000, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'hfffe, 1'b1);
  endtask

  // one- and two-sample blocks: the window folds onto the same entries
  task automatic test_tiny_blocks();
    send_word(16'hffff, 1'b1);
    send_word(16'h1234, 1'b0);
    send_word(16'hffff, 1'b1);
  endtask

  task automatic test_zero_window();
    set_window('0);
    send_word(16'h00ff, 1'b0);
    send_word(16'hff00, 1'b0);
    send_word(16'h5a5a, 1'b1);
  endtask

  task automatic test_wide_windows();
    set_window(5'd31);
    repeat (3) send_word(16'hffff, 1'b0);
    send_word(16'hffff, 1'b1);
    set_window(5'd16);
    send_word(16'h0003, 1'b0);
    send_word(16'hfff0, 1'b0);
    send_word(16'h7777, 1'b1);
    set_window(5'd1);
    send_word(16'haaaa, 1'b0);
    send_word(16'h5555, 1'b1);
  endtask

  // more words than the store holds; the extras are dropped
  task automatic test_store_overflow();
    set_window(5'($urandom_range(1, 16)));
    send_block(cma_pkg::BLOCK_LENGTH + 2);
  endtask

  task automatic test_random_blocks(input int pct, input int budget);
    int sent;
    int len;
    sent     = 0;
    idle_pct = pct;
    while (sent < budget) begin
      if ($urandom_range(2) == 0)
        set_window(($urandom_range(3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16)));
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_block(len);
      sent += len;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_tiny_blocks();
    test_zero_window();
    test_wide_windows();
    test_store_overflow();
    test_random_blocks(0, 30);
    test_random_blocks(79, 30);
    test_random_blocks(35, 30);

    drain();
    repeat (40) @(posedge clk);
    if (expected_avgs.size() != 0) begin
      $error("%0d averages never arrived", expected_avgs.size());
      mismatches++;
    end

    $display("%0d sample words in %0d blocks, %0d averages compared", words_sent,
             blocks_closed, avgs_checked);
    $display("windows 0 to 31, one-sample blocks and an overflowing store were exercised");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
